@@ sv/lzsswd_pkg.sv @@
package lzsswd_pkg;

  localparam int WIN_AW    = 11;
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam int FILL_W    = WIN_AW + 1;
  localparam int BB_W      = 24;
  localparam int CNT_W     = 5;
  localparam int FIELD_W   = 11;
  localparam int LEN_W     = 5;

  localparam logic [WIN_AW-1:0] WIN_START = 11'h7ef;
  localparam logic [7:0]        FILL_BYTE = 8'h20;

  // token field being collected
  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_OFS  = 2'd2;
  localparam logic [1:0] PH_CNT  = 2'd3;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       stream_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       run_last;
    logic       finished;
  } out_beat_t;

  typedef struct packed {
    logic       load;
    logic       consume;
    logic [1:0] phase;
  } bb_ctrl_t;

  typedef struct packed {
    logic               avail;
    logic [FIELD_W-1:0] value;
  } bb_field_t;

  typedef struct packed {
    logic       push;
    logic       flush;
    logic       fin;
    logic [7:0] data;
  } ob_ctrl_t;

  function automatic logic [CNT_W-1:0] field_width(input logic [1:0] ph);
    logic [CNT_W-1:0] w;
    case (ph)
      PH_FLAG: w = 5'd1;
      PH_LIT:  w = 5'd8;
      PH_OFS:  w = 5'd11;
      default: w = 5'd4;
    endcase
    return w;
  endfunction

  function automatic logic [FIELD_W-1:0] field_mask(input logic [1:0] ph);
    logic [FIELD_W-1:0] m;
    case (ph)
      PH_FLAG: m = 11'h001;
      PH_LIT:  m = 11'h0ff;
      PH_OFS:  m = 11'h7ff;
      default: m = 11'h00f;
    endcase
    return m;
  endfunction

endpackage

@@ sv/lzsswd_ram.sv @@
module lzsswd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lzsswd_bitbuf.sv @@
module lzsswd_bitbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lzsswd_pkg::bb_ctrl_t  ctrl,
  input  logic [7:0]            din,
  output lzsswd_pkg::bb_field_t field
);

  logic [lzsswd_pkg::BB_W-1:0]  bits_r, bits_nxt;
  logic [lzsswd_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [lzsswd_pkg::CNT_W-1:0] need;
  logic [lzsswd_pkg::CNT_W-1:0] sh;
  logic [lzsswd_pkg::BB_W-1:0]  shifted;

  assign need    = lzsswd_pkg::field_width(ctrl.phase);
  assign sh      = count_r - need;
  assign shifted = bits_r >> sh;

  assign field.avail = (count_r >= need);
  assign field.value = shifted[lzsswd_pkg::FIELD_W-1:0] & lzsswd_pkg::field_mask(ctrl.phase);

  always_comb begin
    bits_nxt  = bits_r;
    count_nxt = count_r;
    if (ctrl.load) begin
      bits_nxt  = {bits_r[lzsswd_pkg::BB_W-9:0], din};
      count_nxt = count_r + 5'd8;
    end else if (ctrl.consume) begin
      count_nxt = count_r - need;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

endmodule

@@ sv/lzsswd_outbuf.sv @@
module lzsswd_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lzsswd_pkg::ob_ctrl_t  ctrl,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lzsswd_pkg::out_beat_t out_beat
);

  // one byte held back until it is known whether it closes the beat run
  logic                  hold_valid_r, hold_valid_nxt;
  logic [7:0]            hold_r, hold_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lzsswd_pkg::out_beat_t out_r, out_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign ready     = !hold_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (ctrl.push && ready) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = ctrl.data;
      if (hold_valid_r) begin
        out_valid_nxt       = 1'b1;
        out_nxt.plain_byte  = hold_r;
        out_nxt.run_last    = 1'b0;
        out_nxt.finished    = 1'b0;
      end
    end else if (ctrl.flush && ready) begin
      hold_valid_nxt = 1'b0;
      if (hold_valid_r) begin
        out_valid_nxt       = 1'b1;
        out_nxt.plain_byte  = hold_r;
        out_nxt.run_last    = 1'b1;
        out_nxt.finished    = ctrl.fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ sv/lzss_window_decompressor_top.sv @@
// Channel | Ports                                  | Beat
// in      | in_valid, in_stall, in_beat            | packed_byte, stream_last
// out     | out_valid, out_stall, out_beat         | plain_byte, run_last, finished
// cfg     | cfg_wr_en, cfg_wr_data                 | output_length
//
// Per packed byte the sequencer accepts the byte, decodes its token fields, primes
// the window read and copies bytes, and closes with the empty field check and the flush.
// The window RAM read/write loop sets the copy rate at one byte per cycle while the output is not stalled.
// Unwritten window entries read as space via a fill count.
// A stalled output holds literal and copy output and the flush; input is taken only between bytes.
module lzss_window_decompressor_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lzsswd_pkg::in_beat_t  in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lzsswd_pkg::out_beat_t out_beat,
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_COPY   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam int AW = lzsswd_pkg::WIN_AW;
  localparam int FW = lzsswd_pkg::FILL_W;
  localparam int LW = lzsswd_pkg::LEN_W;
  localparam logic [FW-1:0] FILL_MAX = FW'(lzsswd_pkg::WIN_DEPTH);

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [AW-1:0] offset_r, offset_nxt;
  logic [31:0]   length_r, length_nxt;
  logic [31:0]   produced_r, produced_nxt;
  logic          stopped_r, stopped_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          last_r, last_nxt;
  logic [LW-1:0] copy_len_r, copy_len_nxt;
  logic [LW-1:0] rd_i_r, rd_i_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          fwd_r, fwd_nxt;
  logic [7:0]    fwd_data_r, fwd_data_nxt;
  logic          rd_fill_r, rd_fill_nxt;

  lzsswd_pkg::bb_ctrl_t  bb_ctrl;
  lzsswd_pkg::bb_field_t field;
  lzsswd_pkg::ob_ctrl_t  ob_ctrl;
  logic                  ob_ready;

  logic          emit_en;
  logic [7:0]    emit_byte;
  logic [7:0]    copy_byte;
  logic [7:0]    ram_dout;
  logic          ram_re;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_rel;
  logic [FW-1:0] fill_after;
  logic [31:0]   produced_inc;
  logic          limit_hit;
  logic          copy_stop;
  logic          copy_hold;
  logic          issue;

  assign in_stall = (state_r != ST_IDLE);

  assign copy_byte = fwd_r ? fwd_data_r : (rd_fill_r ? ram_dout : lzsswd_pkg::FILL_BYTE);

  assign emit_en = ((state_r == ST_DECODE) && !stopped_r && field.avail &&
                    (phase_r == lzsswd_pkg::PH_LIT) && ob_ready) ||
                   ((state_r == ST_COPY) && rd_pend_r && ob_ready);
  assign emit_byte = (state_r == ST_COPY) ? copy_byte : field.value[7:0];

  assign produced_inc = produced_r + 32'd1;
  assign limit_hit    = (produced_inc >= length_r);
  assign fill_after   = (emit_en && (fill_r != FILL_MAX)) ? fill_r + 1'b1 : fill_r;

  assign rd_addr = offset_r + AW'(rd_i_r);
  assign rd_rel  = rd_addr - lzsswd_pkg::WIN_START;

  assign copy_stop = emit_en && limit_hit;
  assign copy_hold = rd_pend_r && !ob_ready;
  assign issue     = (state_r == ST_COPY) && !copy_hold && !copy_stop &&
                     (rd_i_r != copy_len_r);
  assign ram_re    = issue;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    offset_nxt   = offset_r;
    length_nxt   = length_r;
    produced_nxt = produced_r;
    stopped_nxt  = stopped_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_after;
    last_nxt     = last_r;
    copy_len_nxt = copy_len_r;
    rd_i_nxt     = rd_i_r;
    rd_pend_nxt  = rd_pend_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    rd_fill_nxt  = rd_fill_r;

    bb_ctrl.load    = 1'b0;
    bb_ctrl.consume = 1'b0;
    bb_ctrl.phase   = phase_r;

    ob_ctrl.push  = emit_en;
    ob_ctrl.flush = 1'b0;
    ob_ctrl.fin   = stopped_r | last_r;
    ob_ctrl.data  = emit_byte;

    if (cfg_wr_en) begin
      length_nxt = cfg_wr_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stopped_r) begin
            stopped_nxt = 1'b1;
          end else if (produced_r >= length_r) begin
            stopped_nxt = 1'b1;
          end else begin
            bb_ctrl.load = 1'b1;
            last_nxt     = in_beat.stream_last;
            state_nxt    = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        if (stopped_r || !field.avail) begin
          state_nxt = ST_FINISH;
        end else begin
          case (phase_r)
            lzsswd_pkg::PH_FLAG: begin
              bb_ctrl.consume = 1'b1;
              phase_nxt = field.value[0] ? lzsswd_pkg::PH_LIT : lzsswd_pkg::PH_OFS;
            end
            lzsswd_pkg::PH_LIT: begin
              if (ob_ready) begin
                bb_ctrl.consume = 1'b1;
                phase_nxt       = lzsswd_pkg::PH_FLAG;
              end
            end
            lzsswd_pkg::PH_OFS: begin
              bb_ctrl.consume = 1'b1;
              offset_nxt      = field.value[AW-1:0];
              phase_nxt       = lzsswd_pkg::PH_CNT;
            end
            default: begin
              bb_ctrl.consume = 1'b1;
              copy_len_nxt    = {1'b0, field.value[3:0]} + 5'd2;
              rd_i_nxt        = '0;
              rd_pend_nxt     = 1'b0;
              phase_nxt       = lzsswd_pkg::PH_FLAG;
              state_nxt       = ST_COPY;
            end
          endcase
        end
      end
      ST_COPY: begin
        if (issue) begin
          rd_i_nxt     = rd_i_r + 1'b1;
          rd_pend_nxt  = 1'b1;
          // RAM returns old data when the read hits the byte written this cycle
          fwd_nxt      = emit_en && (wp_r == rd_addr);
          fwd_data_nxt = copy_byte;
          rd_fill_nxt  = ({1'b0, rd_rel} < fill_after);
        end else if (emit_en) begin
          rd_pend_nxt = 1'b0;
        end
        if (copy_stop) begin
          state_nxt = ST_FINISH;
        end else if ((rd_i_r == copy_len_r) && (!rd_pend_r || emit_en)) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_FINISH: begin
        if (ob_ready) begin
          ob_ctrl.flush = 1'b1;
          stopped_nxt   = stopped_r | last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit_en) begin
      produced_nxt = produced_inc;
      wp_nxt       = wp_r + 1'b1;
      if (limit_hit) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= lzsswd_pkg::PH_FLAG;
      offset_r   <= '0;
      length_r   <= '0;
      produced_r <= '0;
      stopped_r  <= 1'b0;
      wp_r       <= lzsswd_pkg::WIN_START;
      fill_r     <= '0;
      last_r     <= 1'b0;
      copy_len_r <= '0;
      rd_i_r     <= '0;
      rd_pend_r  <= 1'b0;
      fwd_r      <= 1'b0;
      rd_fill_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      offset_r   <= offset_nxt;
      length_r   <= length_nxt;
      produced_r <= produced_nxt;
      stopped_r  <= stopped_nxt;
      wp_r       <= wp_nxt;
      fill_r     <= fill_nxt;
      last_r     <= last_nxt;
      copy_len_r <= copy_len_nxt;
      rd_i_r     <= rd_i_nxt;
      rd_pend_r  <= rd_pend_nxt;
      fwd_r      <= fwd_nxt;
      rd_fill_r  <= rd_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= fwd_data_nxt;
  end

  lzsswd_bitbuf u_bitbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (bb_ctrl),
    .din   (in_beat.packed_byte),
    .field (field)
  );

  lzsswd_ram #(
    .WIDTH (8),
    .DEPTH (lzsswd_pkg::WIN_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (emit_en),
    .waddr (wp_r),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_dout)
  );

  lzsswd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ob_ctrl),
    .ready     (ob_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> (rd_i_r <= copy_len_r))
    else $error("copy read index past copy length");

  a_no_emit_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en |-> !stopped_r)
    else $error("byte emitted after stop");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(stopped_r))
    else $error("stop flag cleared without reset");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond window depth");

endmodule

@@ test/tb_lzss_window_decompressor_top.sv @@
module tb_lzss_window_decompressor_top;
  import lzsswd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_RUN = 17;
  localparam int TOKEN_BITS [4] = '{1, 8, 11, 4};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  lzss_window_decompressor_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // decoder shadow state
  logic [7:0]  hist [WIN_DEPTH];
  logic [10:0] wpos;
  logic [23:0] pbits;
  int unsigned pcnt;
  logic [31:0] produced;
  logic [31:0] out_len;
  logic [1:0]  phase;
  logic [10:0] mofs;
  bit          halted;

  out_beat_t plain_expected[$];
  out_beat_t step_run[$];
  bit        gen_bits[$];
  int        errors = 0;
  int        packed_sent = 0;
  int        cycle_cnt = 0;
  bit        steady = 1'b0;

  initial forever #6 clk = ~clk;

  always @(negedge clk) out_stall <= !steady && ($urandom_range(99) < 17);

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (plain_expected.size() == 0) begin
        $error("unexpected beat: plain_byte %h run_last %b finished %b",
               out_beat.plain_byte, out_beat.run_last, out_beat.finished);
        errors++;
      end else begin
        want = plain_expected.pop_front();
        if (out_beat.plain_byte !== want.plain_byte) begin
          $error("plain_byte expected %h actual %h", want.plain_byte, out_beat.plain_byte);
          errors++;
        end
        if (out_beat.run_last !== want.run_last) begin
          $error("run_last expected %b actual %b", want.run_last, out_beat.run_last);
          errors++;
        end
        if (out_beat.finished !== want.finished) begin
          $error("finished expected %b actual %b", want.finished, out_beat.finished);
          errors++;
        end
      end
    end
  end

  function automatic void emit_plain(input logic [7:0] b);
    if (step_run.size() >= MAX_RUN) return;
    hist[wpos] = b;
    wpos = wpos + 11'd1;
    produced = produced + 32'd1;
    step_run.push_back('{plain_byte: b, run_last: 1'b0, finished: 1'b0});
    if (produced >= out_len) halted = 1'b1;
  endfunction

  function automatic void decode_packed(input logic [7:0] b, input logic last);
    int unsigned need;
    logic [10:0] v;
    step_run.delete();
    if (halted) return;
    if (produced >= out_len) begin
      halted = 1'b1;
      return;
    end
    pbits = {pbits[15:0], b};
    pcnt += 8;
    while (!halted) begin
      need = TOKEN_BITS[phase];
      if (pcnt < need) break;
      pcnt -= need;
      v = 11'((32'(pbits) >> pcnt) & ((32'd1 << need) - 32'd1));
      pbits = 24'(32'(pbits) & ((32'd1 << pcnt) - 32'd1));
      case (phase)
        PH_FLAG: phase = v[0] ? PH_LIT : PH_OFS;
        PH_LIT: begin
          emit_plain(v[7:0]);
          phase = PH_FLAG;
        end
        PH_OFS: begin
          mofs = v;
          phase = PH_CNT;
        end
        default: begin
          for (int i = 0; i < int'(v) + 2 && !halted; i++) emit_plain(hist[11'(mofs + i)]);
          phase = PH_FLAG;
        end
      endcase
    end
    if (last) halted = 1'b1;
    if (step_run.size() > 0) begin
      step_run[$].run_last = 1'b1;
      step_run[$].finished = halted;
    end
    foreach (step_run[i]) plain_expected.push_back(step_run[i]);
  endfunction

  task automatic send_packed(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= '{packed_byte: b, stream_last: last};
    do @(posedge clk); while (in_stall);
    packed_sent++;
    decode_packed(b, last);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (plain_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    out_len = v;
  endtask

  function automatic void push_field(input logic [15:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) gen_bits.push_back(v[i]);
  endfunction

  task automatic ship_bytes(input bit mark_last);
    logic [7:0] b;
    while (gen_bits.size() >= 8) begin
      for (int i = 7; i >= 0; i--) b[i] = gen_bits.pop_front();
      send_packed(b, mark_last && gen_bits.size() == 0);
    end
  endtask

  task automatic put_literal(input logic [7:0] b);
    push_field(16'd1, 1);
    push_field({8'd0, b}, 8);
    ship_bytes(1'b0);
  endtask

  task automatic put_copy(input logic [10:0] ofs, input logic [3:0] cnt);
    push_field(16'd0, 1);
    push_field({5'd0, ofs}, 11);
    push_field({12'd0, cnt}, 4);
    ship_bytes(1'b0);
  endtask

  // raw byte, then complete whatever token it left open so framing resumes
  task automatic put_noise(input logic [7:0] b);
    int fill;
    if (gen_bits.size() != 0) return;
    send_packed(b, 1'b0);
    if (!halted && phase != PH_FLAG) begin
      fill = TOKEN_BITS[phase] - int'(pcnt) + (phase == PH_OFS ? 4 : 0);
      push_field(16'($urandom), fill);
    end
  endtask

  task automatic test_length_register_extremes();
    write_length(32'd0);
    write_length(32'hffff_ffff);
  endtask

  task automatic test_directed_tokens();
    put_noise(8'hff);
    put_literal(8'h00);
    put_literal(8'hff);
    put_literal(8'h5a);
    put_literal(8'ha5);
    put_copy(11'h000, 4'd0);        // untouched window reads as spaces
    put_copy(11'h7ff, 4'd15);       // offset wraps past the window end
    put_copy(wpos - 11'd1, 4'd15);  // overlapping copy, run of one byte
    put_copy(wpos, 4'd3);           // source starts at the write position
    put_copy(wpos - 11'd4, 4'd15);
    put_literal(8'h81);
    while (gen_bits.size() != 0) put_literal(8'($urandom));
    put_noise(8'h00);
    while (gen_bits.size() % 8 != 0) put_literal(8'h7e);
    ship_bytes(1'b0);
    settle();
  endtask

  task automatic test_random_stream();
    int start;
    int pick;
    start = packed_sent;
    while (packed_sent - start < 200) begin
      steady = (packed_sent - start >= 60) && (packed_sent - start < 130);
      if (packed_sent - start >= 100 && packed_sent - start < 102) begin
        settle();
        write_length(produced + 32'd1_000_000 + 32'($urandom_range(65535)));
      end
      pick = $urandom_range(99);
      if (pick < 45) put_literal(8'($urandom_range(255)));
      else if (pick < 85) put_copy(wpos - 11'($urandom_range(40, 1)), 4'($urandom_range(15)));
      else if (pick < 93) put_copy(11'($urandom), 4'($urandom));
      else put_noise(8'($urandom));
    end
    steady = 1'b0;
    settle();
  endtask

  // length reached inside a copy on the byte that also ends the stream
  task automatic test_length_cutoff();
    write_length(produced + 32'd5);
    put_copy(wpos - 11'd3, 4'd15);
    while (gen_bits.size() % 8 != 0) gen_bits.push_back(1'b0);
    ship_bytes(1'b1);
    send_packed(8'($urandom), 1'b0);
    send_packed(8'($urandom), 1'b1);
    settle();
  endtask

  initial begin
    foreach (hist[i]) hist[i] = FILL_BYTE;
    wpos = WIN_START;
    pbits = '0;
    pcnt = 0;
    produced = '0;
    out_len = '0;
    phase = PH_FLAG;
    mofs = '0;
    halted = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_length_register_extremes();
    test_directed_tokens();
    test_random_stream();
    test_length_cutoff();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
